// ===== hw/rtl/anap_pkg.sv =====
// anap_pkg: shared constants, phase codes and link types for the area.node
// address parser. No dependencies; every other file of the block imports it.

package anap_pkg;

   // field widths
   localparam int CH_W      = 8;
   localparam int ADDR_W    = 16;
   localparam int PHASE_W   = 4;
   localparam int AREA_W    = 7;
   localparam int NODE_W    = 14;
   localparam int AREA_FLD  = 6;
   localparam int NODE_FLD  = 10;

   // limits of a well-formed address
   localparam logic [AREA_W-1:0] AREA_MAX = AREA_W'(63);
   localparam logic [NODE_W-1:0] NODE_MAX = NODE_W'(1023);

   // character codes
   localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
   localparam logic [CH_W-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
   localparam logic [CH_W-1:0] CH_LC_Z  = 8'h7A;

   // parser phase codes
   localparam logic [PHASE_W-1:0] PH_SKIP  = 4'd0;
   localparam logic [PHASE_W-1:0] PH_AREA1 = 4'd1;
   localparam logic [PHASE_W-1:0] PH_DOT   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_NODE0 = 4'd3;
   localparam logic [PHASE_W-1:0] PH_NODE1 = 4'd4;
   localparam logic [PHASE_W-1:0] PH_NODE2 = 4'd5;
   localparam logic [PHASE_W-1:0] PH_NODE3 = 4'd6;
   localparam logic [PHASE_W-1:0] PH_NODE4 = 4'd7;
   localparam logic [PHASE_W-1:0] PH_DONE  = 4'd8;

   // input register to parser core
   typedef struct packed {
      logic            valid;
      logic [CH_W-1:0] ch;
   } anap_char_type;

   // parser core to result register
   typedef struct packed {
      logic              load;
      logic              valid_res;
      logic [ADDR_W-1:0] address;
   } anap_result_type;

endpackage

// ===== hw/rtl/anap_if.sv =====
// anap_req_if and anap_rsp_if: valid/ready channels of the parser.
// Depends on anap_pkg for the payload widths.

interface anap_req_if
   import anap_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;

   modport source (output valid, output ch, input ready);
   modport sink   (input valid, input ch, output ready);
endinterface

interface anap_rsp_if
   import anap_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              valid_res;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output valid_res, output address, input ready);
   modport sink   (input valid, input valid_res, input address, output ready);
endinterface

// ===== hw/rtl/anap_in_stage.sv =====
// anap_in_stage: input register holding one character item.
// Depends on anap_pkg and anap_req_if.

module anap_in_stage
   import anap_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   anap_req_if.sink      req_bus,
   input  logic          advance,
   output anap_char_type char_out
);

   logic            valid_ff, valid_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic            take;

   // take a new item when empty or when the held one moves on
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   // next values
   always_comb begin
      valid_in = valid_ff;
      ch_in    = ch_ff;
      if (take) begin
         valid_in = 1'b1;
         ch_in    = req_bus.ch;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // control register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      ch_ff <= ch_in;
   end

   assign char_out.valid = valid_ff;
   assign char_out.ch    = ch_ff;

endmodule

// ===== hw/rtl/anap_core.sv =====
// anap_core: parser phase, area and node accumulators and verdict.
// Depends on anap_pkg.

module anap_core
   import anap_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  anap_char_type   char_in,
   input  logic            out_free,
   output logic            advance,
   output anap_result_type result
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   logic [NODE_W-1:0]  node_ff, node_in;
   logic               verdict_ff, verdict_in;

   logic               is_nul, is_dot, is_dig, is_let, range_ok, end_ok;
   logic [3:0]         digit;
   logic [AREA_W-1:0]  area_x10;
   logic [NODE_W-1:0]  node_x10;

   // character classes
   assign is_nul = (char_in.ch == CH_NUL);
   assign is_dot = (char_in.ch == CH_DOT);
   assign is_dig = (char_in.ch >= CH_ZERO) && (char_in.ch <= CH_NINE);
   assign is_let = ((char_in.ch >= CH_UC_A) && (char_in.ch <= CH_UC_Z)) ||
                   ((char_in.ch >= CH_LC_A) && (char_in.ch <= CH_LC_Z));
   assign digit  = is_dig ? 4'(char_in.ch - CH_ZERO) : 4'd0;

   // times ten by shift and add
   assign area_x10 = AREA_W'({area_ff, 3'b000}) + AREA_W'({area_ff, 1'b0})
                     + AREA_W'(digit);
   assign node_x10 = NODE_W'({node_ff, 3'b000}) + NODE_W'({node_ff, 1'b0})
                     + NODE_W'(digit);

   assign range_ok = (node_ff != '0) && (node_ff <= NODE_MAX) &&
                     (area_ff != '0) && (area_ff <= AREA_MAX);

   // a NUL item needs the result register free
   assign advance = char_in.valid && (!is_nul || out_free);

   // verdict given at the end of the string
   always_comb begin
      case (phase_ff)
         PH_NODE1, PH_NODE2, PH_NODE3, PH_NODE4: end_ok = range_ok;
         PH_SKIP, PH_AREA1, PH_DOT, PH_NODE0:    end_ok = 1'b0;
         default:                                end_ok = verdict_ff;
      endcase
   end

   assign result.load      = advance && is_nul;
   assign result.valid_res = end_ok;
   assign result.address   = end_ok ? {area_ff[AREA_FLD-1:0], node_ff[NODE_FLD-1:0]}
                                    : '0;

   // phase update for one character
   always_comb begin
      phase_in   = phase_ff;
      area_in    = area_ff;
      node_in    = node_ff;
      verdict_in = verdict_ff;
      if (advance) begin
         if (is_nul) begin
            phase_in   = PH_SKIP;
            area_in    = '0;
            node_in    = '0;
            verdict_in = 1'b0;
         end else begin
            case (phase_ff)
               PH_SKIP: begin
                  if (is_dig) begin
                     area_in  = AREA_W'(digit);
                     phase_in = PH_AREA1;
                  end
               end
               PH_AREA1: begin
                  if (is_dig) begin
                     area_in  = area_x10;
                     phase_in = PH_DOT;
                  end else if (is_dot) begin
                     phase_in = PH_NODE0;
                  end else begin
                     verdict_in = 1'b0;
                     phase_in   = PH_DONE;
                  end
               end
               PH_DOT: begin
                  if (is_dot) begin
                     phase_in = PH_NODE0;
                  end else begin
                     verdict_in = 1'b0;
                     phase_in   = PH_DONE;
                  end
               end
               PH_NODE0: begin
                  if (is_dig) begin
                     node_in  = NODE_W'(digit);
                     phase_in = PH_NODE1;
                  end else begin
                     verdict_in = 1'b0;
                     phase_in   = PH_DONE;
                  end
               end
               PH_NODE1, PH_NODE2, PH_NODE3: begin
                  if (is_dig) begin
                     node_in  = node_x10;
                     phase_in = phase_ff + 4'd1;
                  end else begin
                     verdict_in = !is_let && range_ok;
                     phase_in   = PH_DONE;
                  end
               end
               PH_NODE4: begin
                  verdict_in = !is_dig && !is_let && range_ok;
                  phase_in   = PH_DONE;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_SKIP;
         area_ff    <= '0;
         node_ff    <= '0;
         verdict_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         area_ff    <= area_in;
         node_ff    <= node_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

// ===== hw/rtl/anap_out_stage.sv =====
// anap_out_stage: result register feeding the response channel.
// Depends on anap_pkg and anap_rsp_if.

module anap_out_stage
   import anap_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  anap_result_type result,
   output logic            out_free,
   anap_rsp_if.source      rsp_bus
);

   logic              valid_ff, valid_in;
   logic              res_ff, res_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // free when empty or the held item leaves this cycle
   assign out_free = !valid_ff || rsp_bus.ready;

   // next values
   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      addr_in  = addr_ff;
      if (result.load) begin
         valid_in = 1'b1;
         res_in   = result.valid_res;
         addr_in  = result.address;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      addr_ff <= addr_in;
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.valid_res = res_ff;
   assign rsp_bus.address   = addr_ff;

endmodule

// ===== hw/rtl/area_node_address_parser_top.sv =====
// area_node_address_parser_top: area.node address parser, one character item
// per cycle unless a NUL item waits for a busy result register. A NUL item
// passes through the input register and then the result register. Throughput:
// one character per cycle; a stalled result stalls NUL items and later ones.
// Reset (synchronous, active high) empties both registers and returns the
// parser to skipping leading characters. Depends on anap_pkg, anap_if, stages.

module area_node_address_parser_top
   import anap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   anap_req_if.sink   req_bus,
   anap_rsp_if.source rsp_bus
);

   anap_char_type   char_link;
   anap_result_type result_link;
   logic            advance;
   logic            out_free;

   anap_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .advance  (advance),
      .char_out (char_link)
   );

   anap_core u_core (
      .clock    (clock),
      .reset    (reset),
      .char_in  (char_link),
      .out_free (out_free),
      .advance  (advance),
      .result   (result_link)
   );

   anap_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result_link),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

endmodule
